@@ hw/rtl/ssm_pkg.sv @@
// Shared types and constants of the sprite slot multiplexer.
package ssm_pkg;

  localparam int POS_W = 16;
  localparam int OFF_W = 16;
  localparam int SLOT_IDX_W = 3;
  localparam int NSLOT_W = 4;
  localparam int HEIGHT_W = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic REG_ACTIVE_SLOTS = 1'b0;
  localparam logic REG_SPRITE_HEIGHT = 1'b1;

  localparam logic [NSLOT_W-1:0] ACTIVE_SLOTS_RST = 4'd8;
  localparam logic [HEIGHT_W-1:0] SPRITE_HEIGHT_RST = 8'd16;

  typedef struct packed {
    logic [NSLOT_W-1:0] active_slots;
    logic [HEIGHT_W-1:0] sprite_height;
  } cfg_t;

  typedef struct packed {
    logic finish;
    logic [POS_W-1:0] pos;
  } req_t;

endpackage

@@ hw/rtl/ssm_if.sv @@
// Request and result channel interfaces of the sprite slot multiplexer.
interface ssm_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [15:0] position_word;

  modport source (output valid, output opcode, output position_word, input ready);
  modport sink (input valid, input opcode, input position_word, output ready);
endinterface

interface ssm_out_if;
  logic valid;
  logic ready;
  logic [2:0] slot_index;
  logic [15:0] word_offset;
  logic [15:0] data_word;
  logic last;

  modport source (output valid, output slot_index, output word_offset, output data_word,
                  output last, input ready);
  modport sink (input valid, input slot_index, input word_offset, input data_word,
                input last, output ready);
endinterface

@@ hw/rtl/sprite_slot_multiplexer_core.sv @@
// Top level of the sprite slot multiplexer: register port, front and back ends.
//
// Usage: each request on "items" carries an opcode and a packed position
// word (Y high byte, X low byte). A place request picks the active slot
// with the lowest free line (lowest index on a tie) and, if that line is
// not past the position, yields two writes on "results": the position word
// and the end word; otherwise it yields nothing. A finish request yields two
// zero words per active slot and clears all slot state. "last" marks the
// final write of each request.
// A request passes through the two-entry queue and the output register
// before its first write appears. The back-end sequencer and its single
// output register take a new request only once all writes of the previous
// one are loaded; a finish covers each effective slot (active_slots held
// to 1..MAX_SLOTS). Requests queue in two entries, so the front accepts
// until both are full; a stall holds the output register and the sequencer.
// Reset: slot state clears, active_slots = 8, sprite_height = 16.
// Registers: active_slots at byte 0, sprite_height at byte 4.
module sprite_slot_multiplexer_core
  import ssm_pkg::*;
#(
  parameter int MAX_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  ssm_in_if.sink             items,
  ssm_out_if.source          results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  logic q_valid;
  req_t q_req;
  logic q_pop;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  // Register writes complete on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_slots  <= ACTIVE_SLOTS_RST;
      cfg.sprite_height <= SPRITE_HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_ACTIVE_SLOTS:  cfg.active_slots  <= pwdata[NSLOT_W-1:0];
        REG_SPRITE_HEIGHT: cfg.sprite_height <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ACTIVE_SLOTS:  prdata = PDATA_W'(cfg.active_slots);
      REG_SPRITE_HEIGHT: prdata = PDATA_W'(cfg.sprite_height);
      default:           prdata = '0;
    endcase
  end

  ssm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop)
  );

  ssm_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

@@ hw/rtl/ssm_front.sv @@
// Front end: accept requests, classify them and hold them in a two-entry queue.
module ssm_front
  import ssm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ssm_in_if.sink       items,
  output logic         q_valid,
  output req_t         q_req,
  input  logic         q_pop
);

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign items.ready = (count != 2'd2);
  assign push        = items.valid && items.ready;
  assign q_valid     = (count != 2'd0);
  assign q_req       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].finish <= (items.opcode == OP_FINISH);
      mem[wr_ptr].pos    <= items.position_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      if (push && !q_pop) count <= count + 2'd1;
      else if (!push && q_pop) count <= count - 2'd1;
    end
  end

endmodule

@@ hw/rtl/ssm_back.sv @@
// Back end: slot choice, slot state and the registered write stream.
module ssm_back
  import ssm_pkg::*;
#(
  parameter int MAX_SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  input  req_t         q_req,
  output logic         q_pop,
  ssm_out_if.source    results
);

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  localparam logic [1:0] ST_PICK = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]            state;
  logic [POS_W-1:0]      free_line    [MAX_SLOTS];
  logic [OFF_W-1:0]      write_offset [MAX_SLOTS];

  logic                  out_valid;
  logic [SLOT_IDX_W-1:0] out_slot;
  logic [OFF_W-1:0]      out_off;
  logic [POS_W-1:0]      out_data;
  logic                  out_last;

  logic [SW-1:0]         cur_slot;
  logic [POS_W-1:0]      end_word;
  logic [SW-1:0]         fin_slot;
  logic                  fin_half;

  logic [NSLOT_W-1:0]    n_eff;
  logic [SW-1:0]         last_slot;
  logic [SW-1:0]         best;
  logic [POS_W-1:0]      best_line;
  logic                  can_load;
  logic [7:0]            end_y;
  logic                  fin_last;

  always_comb begin
    n_eff = cfg.active_slots;
    if (n_eff > NSLOT_W'(MAX_SLOTS)) n_eff = NSLOT_W'(MAX_SLOTS);
    if (n_eff == '0) n_eff = NSLOT_W'(1);
    last_slot = SW'(n_eff - NSLOT_W'(1));
  end

  // Lowest free line among active slots, lowest index on a tie.
  always_comb begin
    best      = '0;
    best_line = free_line[0];
    for (int s = 1; s < MAX_SLOTS; s++) begin
      if ((NSLOT_W'(s) < n_eff) && (free_line[s] < best_line)) begin
        best      = SW'(s);
        best_line = free_line[s];
      end
    end
  end

  assign can_load = !out_valid || results.ready;
  assign q_pop    = (state == ST_PICK) && q_valid && can_load;
  assign end_y    = q_req.pos[15:8] + cfg.sprite_height;
  assign fin_last = fin_half && (fin_slot == last_slot);

  assign results.valid       = out_valid;
  assign results.slot_index  = out_slot;
  assign results.word_offset = out_off;
  assign results.data_word   = out_data;
  assign results.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PICK;
      out_valid <= 1'b0;
      fin_slot  <= '0;
      fin_half  <= 1'b0;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        free_line[s]    <= '0;
        write_offset[s] <= '0;
      end
    end else begin
      if (out_valid && results.ready) out_valid <= 1'b0;
      case (state)
        ST_PICK: begin
          if (q_pop) begin
            if (q_req.finish) begin
              out_valid <= 1'b1;
              out_slot  <= '0;
              out_off   <= write_offset[0];
              out_data  <= '0;
              out_last  <= 1'b0;
              fin_slot  <= '0;
              fin_half  <= 1'b1;
              state     <= ST_FIN;
            end else if (best_line <= q_req.pos) begin
              out_valid <= 1'b1;
              out_slot  <= SLOT_IDX_W'(best);
              out_off   <= write_offset[best];
              out_data  <= q_req.pos;
              out_last  <= 1'b0;
              cur_slot  <= best;
              end_word  <= {end_y, 8'h00};
              state     <= ST_END;
            end
          end
        end
        ST_END: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_slot  <= SLOT_IDX_W'(cur_slot);
            out_off   <= write_offset[cur_slot] + OFF_W'(1);
            out_data  <= end_word;
            out_last  <= 1'b1;
            free_line[cur_slot]    <= end_word + {8'h01, 8'h00};
            write_offset[cur_slot] <= write_offset[cur_slot]
                                      + OFF_W'({cfg.sprite_height, 1'b0}) + OFF_W'(2);
            state     <= ST_PICK;
          end
        end
        ST_FIN: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_slot  <= SLOT_IDX_W'(fin_slot);
            out_off   <= write_offset[fin_slot] + OFF_W'(fin_half);
            out_data  <= '0;
            out_last  <= fin_last;
            if (fin_last) begin
              for (int s = 0; s < MAX_SLOTS; s++) begin
                free_line[s]    <= '0;
                write_offset[s] <= '0;
              end
              state <= ST_PICK;
            end else if (fin_half) begin
              fin_slot <= fin_slot + SW'(1);
              fin_half <= 1'b0;
            end else begin
              fin_half <= 1'b1;
            end
          end
        end
        default: state <= ST_PICK;
      endcase
    end
  end

endmodule
